// File: rtl/lfn_pkg.sv
// ----------------------------------------------------------------------------
// Light flicker noise package
// Shared types, hash constants and per-layer rate selection.
// ----------------------------------------------------------------------------
package lfn_pkg;

  localparam int NUM_LANES = 7;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_FIRE   = 2'd1;
  localparam logic [1:0] KIND_CANDLE = 2'd2;
  localparam logic [1:0] KIND_OTHER  = 2'd3;

  localparam logic [31:0] MIX_C1     = 32'h7FEB352D;
  localparam logic [31:0] MIX_C2     = 32'h846CA68B;
  localparam logic [31:0] HASH_G     = 32'h9E3779B1;
  localparam logic [31:0] HASH_H     = 32'h85EBCA77;
  localparam logic [31:0] SEED_OWNER = 32'd2654435761;
  localparam logic [31:0] SEED_INDEX = 32'd40503;

  localparam logic signed [61:0] ONE_Q52    = 62'sd1 <<< 52;
  localparam logic signed [61:0] FLOOR_Q52  = 62'sd19661 <<< 36;
  localparam logic [19:0]        FLOOR_Q16  = 20'd19661;
  localparam logic signed [26:0] GUTTER_Q24 = 27'sd10066330;
  localparam logic [13:0]        JITTER_W   = 14'd3277;

  typedef logic signed [25:0] wave_t;

  typedef struct packed {
    logic [31:0]        owner_low;
    logic [31:0]        light_index;
    logic [1:0]         flicker_kind;
    logic [31:0]        time_s;
    logic [15:0]        intensity_in;
    logic signed [31:0] pos_x_in;
    logic signed [31:0] pos_y_in;
    logic signed [31:0] pos_z_in;
  } lfn_in_t;

  typedef struct packed {
    logic [15:0]        intensity_out;
    logic signed [31:0] pos_x_out;
    logic signed [31:0] pos_y_out;
    logic signed [31:0] pos_z_out;
  } lfn_out_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic               bypass;
    logic [15:0]        strength;
    logic [15:0]        intensity;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } lfn_pay_t;

  function automatic logic [19:0] rate_sel(input logic [1:0] kind, input logic [2:0] lane);
    logic [19:0] m;
    m = 20'd0;
    case (kind)
      KIND_FIRE: begin
        case (lane)
          3'd0:    m = 20'd85197;
          3'd1:    m = 20'd242483;
          3'd2:    m = 20'd596378;
          3'd3:    m = 20'd45875;
          default: m = 20'd150733;
        endcase
      end
      KIND_CANDLE: begin
        case (lane)
          3'd0:    m = 20'd517734;
          3'd1:    m = 20'd1002701;
          default: m = 20'd0;
        endcase
      end
      KIND_OTHER: begin
        case (lane)
          3'd0:    m = 20'd58982;
          3'd1:    m = 20'd203162;
          default: m = 20'd0;
        endcase
      end
      default: m = 20'd0;
    endcase
    return m;
  endfunction

endpackage

// File: rtl/light_flicker_noise.sv
// ----------------------------------------------------------------------------
// Light flicker noise
// Per-light flicker of intensity and fire position from hashed value noise.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; busy is never raised.
// The rate is set by the fifteen-stage pipeline of seven noise lanes.
// Synchronous active-low reset clears all valid bits and sets strength to 0.25.
// The receiver cannot stall; each result is shown for exactly one cycle.
module light_flicker_noise (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  lfn_pkg::lfn_in_t   in_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  output lfn_pkg::lfn_out_t  out_data
);
  import lfn_pkg::*;

  logic [15:0] strength_r;
  logic        v1_r, v2_r;
  lfn_in_t     in1_r;
  logic [15:0] str1_r;
  logic [31:0] own_p_r, idx_p_r;
  logic [31:0] seed_r, t2_r;
  logic [19:0] m_r [NUM_LANES];
  lfn_pay_t    pay2_r;
  lfn_pay_t    pay_d_r [8];
  logic [7:0]  vd_r;
  wave_t       wave [NUM_LANES];

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= 16'd4096;
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      vd_r       <= '0;
    end else begin
      if (cfg_we) begin
        strength_r <= cfg_wdata;
      end
      v1_r <= start && !busy;
      v2_r <= v1_r;
      vd_r <= {vd_r[6:0], v2_r};
    end
  end

  always_ff @(posedge clk) begin
    in1_r   <= in_data;
    str1_r  <= strength_r;
    own_p_r <= in_data.owner_low * SEED_OWNER;
    idx_p_r <= in_data.light_index * SEED_INDEX;
    seed_r  <= own_p_r + idx_p_r;
    t2_r    <= in1_r.time_s;
    for (int l = 0; l < NUM_LANES; l++) begin
      m_r[l] <= rate_sel(in1_r.flicker_kind, 3'(l));
    end
    pay2_r.kind      <= in1_r.flicker_kind;
    pay2_r.bypass    <= (in1_r.flicker_kind == KIND_NONE) || (str1_r == 16'd0);
    pay2_r.strength  <= str1_r;
    pay2_r.intensity <= in1_r.intensity_in;
    pay2_r.pos_x     <= in1_r.pos_x_in;
    pay2_r.pos_y     <= in1_r.pos_y_in;
    pay2_r.pos_z     <= in1_r.pos_z_in;
    pay_d_r[0] <= pay2_r;
    for (int i = 1; i < 8; i++) begin
      pay_d_r[i] <= pay_d_r[i-1];
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    lfn_noise #(.LANE(l)) u_noise (
      .clk    (clk),
      .t_i    (t2_r),
      .m_i    (m_r[l]),
      .seed_i (seed_r),
      .wave_o (wave[l])
    );
  end

  lfn_mix u_mix (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (vd_r[7]),
    .pay_i     (pay_d_r[7]),
    .wave_i    (wave),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: rtl/lfn_noise.sv
// ----------------------------------------------------------------------------
// Light flicker noise lane
// Eight-stage hashed value noise along scaled time, signed Q1.24 result.
// ----------------------------------------------------------------------------
module lfn_noise #(
  parameter int LANE = 0
) (
  input  logic                clk,
  input  logic [31:0]         t_i,
  input  logic [19:0]         m_i,
  input  logic [31:0]         seed_i,
  output lfn_pkg::wave_t      wave_o
);
  import lfn_pkg::*;

  localparam logic [63:0] LANE_H_FULL = 64'(LANE) * 64'(HASH_H);
  localparam logic [31:0] LANE_H      = LANE_H_FULL[31:0];
  localparam logic [31:0] LANE_HG     = LANE_H + HASH_G;

  logic [51:0] st_r;
  logic [31:0] sh_r;
  logic [31:0] ipk_r, kc_r, kcb_r;
  logic [15:0] f_r, f2_r;
  logic [17:0] tail_r;
  logic [31:0] k_r, kb_r;
  logic [16:0] s_c_r, s_d_r, s_e_r;
  logic [31:0] xa_d_r, xb_d_r, xa_e_r, xb_e_r;
  logic [23:0] a_r, b_r;
  logic signed [42:0] acc_r;
  wave_t wave_r;

  logic [31:0] ipk_full;
  logic [31:0] ff;
  logic [17:0] tail;
  logic [33:0] s_full;
  logic signed [24:0] diff;
  logic signed [42:0] prod;

  always_comb begin
    ipk_full = {12'd0, st_r[51:32]} * HASH_G;
    ff       = f_r * f_r;
    tail     = 18'd196608 - {1'b0, f_r, 1'b0};
    s_full   = f2_r * tail_r;
    diff     = signed'({1'b0, b_r}) - signed'({1'b0, a_r});
    prod     = 43'(diff * signed'({1'b0, s_e_r}));
  end

  always_ff @(posedge clk) begin
    st_r   <= 52'({32'd0, t_i} * {44'd0, m_i});
    sh_r   <= seed_i * HASH_H;
    ipk_r  <= ipk_full;
    f_r    <= st_r[31:16];
    f2_r   <= ff[31:16];
    tail_r <= tail;
    kc_r   <= sh_r + LANE_H;
    kcb_r  <= sh_r + LANE_HG;
    k_r    <= ipk_r + kc_r;
    kb_r   <= ipk_r + kcb_r;
    s_c_r  <= s_full[32:16];
    xa_d_r <= (k_r ^ (k_r >> 16)) * MIX_C1;
    xb_d_r <= (kb_r ^ (kb_r >> 16)) * MIX_C1;
    s_d_r  <= s_c_r;
    xa_e_r <= (xa_d_r ^ (xa_d_r >> 15)) * MIX_C2;
    xb_e_r <= (xb_d_r ^ (xb_d_r >> 15)) * MIX_C2;
    s_e_r  <= s_d_r;
    a_r    <= 24'(xa_e_r ^ (xa_e_r >> 16));
    b_r    <= 24'(xb_e_r ^ (xb_e_r >> 16));
    acc_r  <= signed'({3'd0, a_r, 16'd0}) + prod;
    wave_r <= signed'({1'b0, acc_r[39:16], 1'b0}) - 26'sh1000000;
  end

  assign wave_o = wave_r;

endmodule

// File: rtl/lfn_mix.sv
// ----------------------------------------------------------------------------
// Light flicker noise mixer
// Weights the noise layers, applies the factor floor and the fire jitter.
// ----------------------------------------------------------------------------
module lfn_mix (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  input  lfn_pkg::lfn_pay_t  pay_i,
  input  lfn_pkg::wave_t     wave_i [lfn_pkg::NUM_LANES],
  output logic               out_valid,
  output lfn_pkg::lfn_out_t  out_data
);
  import lfn_pkg::*;

  logic [4:0]  valid_r;
  lfn_pay_t    pay_r [4];

  logic signed [41:0] t0_r, t1_r, t2_r, t3_r;
  logic signed [42:0] jp_r [3];
  logic signed [43:0] v_r;
  logic signed [56:0] jq_r [3];
  logic signed [61:0] fac_r;
  logic signed [31:0] pn_r [3];
  logic signed [31:0] pn4_r [3];
  logic [35:0] io_r;

  logic [13:0] w0, w1;
  logic fire;
  logic signed [26:0] g;
  logic signed [16:0] str_s;
  logic signed [16:0] str2_s;
  logic signed [31:0] pos_in [3];
  logic signed [32:0] psum [3];
  logic signed [31:0] psat [3];
  logic [19:0] f16;
  logic [19:0] io_hi;
  logic [15:0] inten_sat;

  always_comb begin
    fire = (pay_i.kind == KIND_FIRE);
    case (pay_i.kind)
      KIND_FIRE: begin
        w0 = 14'd9175;
        w1 = 14'd5898;
      end
      KIND_CANDLE: begin
        w0 = 14'd3277;
        w1 = 14'd1966;
      end
      default: begin
        w0 = 14'd1311;
        w1 = 14'd655;
      end
    endcase
    g      = 27'(wave_i[3]) - GUTTER_Q24;
    str_s  = signed'({1'b0, pay_i.strength});
    str2_s = signed'({1'b0, pay_r[1].strength});
    pos_in[0] = pay_r[1].pos_x;
    pos_in[1] = pay_r[1].pos_y;
    pos_in[2] = pay_r[1].pos_z;
    for (int i = 0; i < 3; i++) begin
      psum[i] = 33'(pos_in[i]) + 33'(signed'(jq_r[i][56:36]));
      if (psum[i][32] != psum[i][31]) begin
        psat[i] = psum[i][32] ? 32'sh80000000 : 32'sh7FFFFFFF;
      end else begin
        psat[i] = psum[i][31:0];
      end
    end
    if (fac_r < FLOOR_Q52) begin
      f16 = FLOOR_Q16;
    end else begin
      f16 = fac_r[55:36];
    end
    io_hi     = io_r[35:16];
    inten_sat = (io_hi > 20'd65535) ? 16'hFFFF : io_hi[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[3:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    pay_r[0] <= pay_i;
    for (int i = 1; i < 4; i++) begin
      pay_r[i] <= pay_r[i-1];
    end
    t0_r <= 42'(signed'({1'b0, w0}) * wave_i[0]);
    t1_r <= 42'(signed'({1'b0, w1}) * wave_i[1]);
    t2_r <= fire ? 42'(signed'({1'b0, 14'd3277}) * wave_i[2]) : '0;
    t3_r <= (fire && g > 0) ? -(42'(g) <<< 15) : '0;
    for (int i = 0; i < 3; i++) begin
      jp_r[i] <= 43'(wave_i[4+i] * str_s);
      jq_r[i] <= 57'(jp_r[i] * signed'({1'b0, JITTER_W}));
    end
    v_r   <= 44'(t0_r) + 44'(t1_r) + 44'(t2_r) + 44'(t3_r);
    fac_r <= ONE_Q52 + 62'(v_r * str2_s);
    for (int i = 0; i < 3; i++) begin
      pn_r[i]  <= (pay_r[1].kind == KIND_FIRE && !pay_r[1].bypass) ? psat[i] : pos_in[i];
      pn4_r[i] <= pn_r[i];
    end
    io_r <= {16'd0, pay_r[2].intensity} * {16'd0, f16};
    out_data.intensity_out <= pay_r[3].bypass ? pay_r[3].intensity : inten_sat;
    out_data.pos_x_out     <= pn4_r[0];
    out_data.pos_y_out     <= pn4_r[1];
    out_data.pos_z_out     <= pn4_r[2];
  end

  assign out_valid = valid_r[4];

endmodule

// File: rtl/lfn_checker.sv
// ----------------------------------------------------------------------------
// Light flicker noise checker
// Port-level checks of result timing and pass-through behavior.
// ----------------------------------------------------------------------------
module lfn_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input lfn_pkg::lfn_in_t   in_data,
  input logic               out_valid,
  input lfn_pkg::lfn_out_t  out_data
);
  import lfn_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##15 out_valid)
    else $error("Accepted transaction produced no result.");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 15))
    else $error("Result without an accepted transaction.");

  a_none_passes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_data.flicker_kind, 15) == KIND_NONE |->
      out_data.intensity_out == $past(in_data.intensity_in, 15) &&
      out_data.pos_x_out == $past(in_data.pos_x_in, 15))
    else $error("Unflickered light was altered.");

  a_pos_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_data.flicker_kind, 15) != KIND_FIRE |->
      out_data.pos_y_out == $past(in_data.pos_y_in, 15) &&
      out_data.pos_z_out == $past(in_data.pos_z_in, 15))
    else $error("Position moved for a light that is not fire.");

endmodule

bind light_flicker_noise lfn_checker u_lfn_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
